### sv/pdp_pkg.sv
// pdp_pkg: shared types and constants of the clamped pid drive block
// depends on nothing; used by pdp_regs and pid_drive_percent_core
`timescale 1ns / 1ps

package pdp_pkg;

	// fixed point scaling of gains and terms
	localparam int GAIN_FRAC_BITS = 8;

	// field and datapath widths
	localparam int SP_W    = 7;   // setpoint, whole degrees
	localparam int GAIN_W  = 16;  // signed gains
	localparam int MEAS_W  = 12;  // measured sample, tenths of a degree
	localparam int DRIVE_W = 7;   // drive percent
	localparam int ERR_W   = 13;  // error span -2047..3318
	localparam int DIFF_W  = 14;  // error difference span -5365..5365
	localparam int PROD_W  = 30;  // widest product, diff times gain
	localparam int INT_W   = 32;  // integral accumulator
	localparam int SUM_W   = 34;  // p plus integral plus d

	// register map, word index from paddr[3:2]
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam logic [1:0] REG_SETPOINT = 2'd0;
	localparam logic [1:0] REG_GAIN_P   = 2'd1;
	localparam logic [1:0] REG_GAIN_I   = 2'd2;
	localparam logic [1:0] REG_GAIN_D   = 2'd3;

	// clamp limits in fixed point
	localparam logic [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(100);
	localparam logic signed [SUM_W-1:0] SUM_LIMIT = SUM_W'(100) <<< GAIN_FRAC_BITS;
	localparam logic signed [PROD_W-1:0] P_LIMIT = PROD_W'(100) <<< GAIN_FRAC_BITS;
	localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

	// controller settings as held by the register file
	typedef struct packed {
		logic [SP_W-1:0]          setpoint;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
	} pdp_cfg_t;

endpackage

### sv/pdp_regs.sv
// pdp_regs: apb register file holding setpoint and the three gains
// depends on pdp_pkg
`timescale 1ns / 1ps

module pdp_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdp_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdp_pkg::DATA_W-1:0]  pwdata,
	output logic [pdp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output pdp_pkg::pdp_cfg_t           cfg
);

	pdp_pkg::pdp_cfg_t cfg_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				pdp_pkg::REG_SETPOINT: cfg_q.setpoint <= pwdata[pdp_pkg::SP_W-1:0];
				pdp_pkg::REG_GAIN_P:   cfg_q.gain_p   <= pwdata[pdp_pkg::GAIN_W-1:0];
				pdp_pkg::REG_GAIN_I:   cfg_q.gain_i   <= pwdata[pdp_pkg::GAIN_W-1:0];
				pdp_pkg::REG_GAIN_D:   cfg_q.gain_d   <= pwdata[pdp_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, gains sign extended
	always_comb begin
		unique case (reg_idx)
			pdp_pkg::REG_SETPOINT: prdata = pdp_pkg::DATA_W'(cfg_q.setpoint);
			pdp_pkg::REG_GAIN_P:   prdata = pdp_pkg::DATA_W'(cfg_q.gain_p);
			pdp_pkg::REG_GAIN_I:   prdata = pdp_pkg::DATA_W'(cfg_q.gain_i);
			pdp_pkg::REG_GAIN_D:   prdata = pdp_pkg::DATA_W'(cfg_q.gain_d);
			default:               prdata = '0;
		endcase
	end

endmodule

### sv/pid_drive_percent_core.sv
// pid_drive_percent_core: top level of the clamped pid drive controller
// depends on pdp_pkg and pdp_regs
`timescale 1ns / 1ps

// Clamped PID controller. Each input word on s_tdata is one temperature sample
// in tenths of a degree (12 bit signed); each gives exactly one output word on
// m_tdata, the drive in percent (0..100). The error is setpoint*10 minus the
// sample; proportional, integral (Q24.8, saturating) and derivative terms with
// Q8.8 gains are summed, clamped and truncated. When the proportional term
// reaches +-100 the integral is cleared after the output is formed. One sample
// is taken every clock cycle while the output is not stalled; the result is formed
// between the input register and the output register, in a single pass
// of three multipliers, the integral update and the clamp. The integral and
// previous error update once per processed word. Registers: setpoint at 0x0,
// gain_p at 0x4, gain_i at 0x8, gain_d at 0xC; write them only while idle.

module pid_drive_percent_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,   // [11:0] measured, [15:12] zero
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [6:0] drive, [7] zero
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pdp_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdp_pkg::DATA_W-1:0]  pwdata,
	output logic [pdp_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	pdp_pkg::pdp_cfg_t cfg;

	logic                                   valid_s1;
	logic signed [pdp_pkg::MEAS_W-1:0]      meas_s1;
	logic                                   out_valid_q;
	logic [pdp_pkg::DRIVE_W-1:0]            drive_q;
	logic signed [pdp_pkg::INT_W-1:0]       integral_q;
	logic signed [pdp_pkg::ERR_W-1:0]       last_err_q;

	logic                                   advance;
	logic                                   take_in;
	logic [pdp_pkg::ERR_W-3:0]              sp_x10;
	logic signed [pdp_pkg::ERR_W-1:0]       err;
	logic signed [pdp_pkg::DIFF_W-1:0]      diff;
	logic signed [pdp_pkg::PROD_W-1:0]      p_term;
	logic signed [pdp_pkg::PROD_W-1:0]      i_prod;
	logic signed [pdp_pkg::PROD_W-1:0]      d_term;
	logic signed [pdp_pkg::INT_W:0]         int_wide;
	logic signed [pdp_pkg::INT_W-1:0]       int_next;
	logic signed [pdp_pkg::SUM_W-1:0]       sum;
	logic                                   p_clear;
	logic [pdp_pkg::DRIVE_W-1:0]            drive_next;

	pdp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: stage 1 moves on whenever the output register is free
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign take_in  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, drive_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			meas_s1 <= s_tdata[pdp_pkg::MEAS_W-1:0];
		end
	end

	// error and its difference to the previous one
	assign sp_x10 = ({4'b0, cfg.setpoint} << 3) + ({4'b0, cfg.setpoint} << 1);
	assign err    = $signed({2'b0, sp_x10}) - pdp_pkg::ERR_W'(meas_s1);
	assign diff   = pdp_pkg::DIFF_W'(err) - pdp_pkg::DIFF_W'(last_err_q);

	// the three gain products
	assign p_term = pdp_pkg::PROD_W'(err)  * pdp_pkg::PROD_W'(cfg.gain_p);
	assign i_prod = pdp_pkg::PROD_W'(err)  * pdp_pkg::PROD_W'(cfg.gain_i);
	assign d_term = pdp_pkg::PROD_W'(diff) * pdp_pkg::PROD_W'(cfg.gain_d);

	// saturating integral update
	assign int_wide = (pdp_pkg::INT_W+1)'(integral_q) + (pdp_pkg::INT_W+1)'(i_prod);
	always_comb begin
		priority if (int_wide[pdp_pkg::INT_W] == int_wide[pdp_pkg::INT_W-1]) begin
			int_next = int_wide[pdp_pkg::INT_W-1:0];
		end else if (int_wide[pdp_pkg::INT_W]) begin
			int_next = pdp_pkg::INT_MIN;
		end else begin
			int_next = pdp_pkg::INT_MAX;
		end
	end

	// sum and clamp to percent
	assign sum = pdp_pkg::SUM_W'(p_term) + pdp_pkg::SUM_W'(int_next)
		+ pdp_pkg::SUM_W'(d_term);
	always_comb begin
		priority if (sum > pdp_pkg::SUM_LIMIT) begin
			drive_next = pdp_pkg::DRIVE_MAX;
		end else if (sum < 0) begin
			drive_next = '0;
		end else begin
			drive_next = sum[pdp_pkg::GAIN_FRAC_BITS +: pdp_pkg::DRIVE_W];
		end
	end

	// anti windup: large proportional term clears the integral
	assign p_clear = (p_term >= pdp_pkg::P_LIMIT) || (p_term <= -pdp_pkg::P_LIMIT);

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			last_err_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				integral_q <= p_clear ? '0 : int_next;
				last_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_q <= drive_next;
		end
	end

	// checks
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (drive_q <= pdp_pkg::DRIVE_MAX))
		else $error("drive above 100 percent");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> m_tvalid)
		else $error("processed word produced no result");

	a_windup_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && p_clear) |=> (integral_q == '0))
		else $error("integral not cleared on large proportional term");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> ($stable(integral_q) && $stable(last_err_q)))
		else $error("controller state changed without a word");

endmodule

### tb/sv/pid_drive_percent_core_tb.sv
// pid_drive_percent_core_tb: self-checking bench for the clamped pid drive controller
// streams temperature samples, predicts each drive word and compares; depends on pdp_pkg
`timescale 1ns / 1ps

module pid_drive_percent_core_tb;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [15:0]                   s_tdata = '0;   // [11:0] measured, [15:12] zero
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [7:0]                    m_tdata;        // [6:0] drive, [7] zero
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [pdp_pkg::ADDR_W-1:0]    paddr = '0;
	logic [pdp_pkg::DATA_W-1:0]    pwdata = '0;
	logic [pdp_pkg::DATA_W-1:0]    prdata;
	logic                          pready;

	// controller settings and state as the bench tracks them
	logic [pdp_pkg::SP_W-1:0]          sp_cfg = '0;
	logic signed [pdp_pkg::GAIN_W-1:0] kp_cfg = '0;
	logic signed [pdp_pkg::GAIN_W-1:0] ki_cfg = '0;
	logic signed [pdp_pkg::GAIN_W-1:0] kd_cfg = '0;
	logic signed [pdp_pkg::INT_W-1:0]  integ_acc = '0;
	logic signed [15:0]                prev_err = '0;

	logic [pdp_pkg::MEAS_W-1:0]  sample_pend_q[$];
	logic [pdp_pkg::DRIVE_W-1:0] drive_exp_q[$];
	logic [pdp_pkg::DRIVE_W-1:0] exp_drv;
	int unsigned                 err_count = 0;
	int unsigned                 burst_left;
	int unsigned                 gap_left;
	logic [15:0]                 stall_pat;
	int unsigned                 stall_idx;

	pid_drive_percent_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one pid step: error, three terms, saturating integral, clamp, integral clear
	function automatic logic [pdp_pkg::DRIVE_W-1:0] pid_step(
		input logic signed [pdp_pkg::MEAS_W-1:0] meas);
		longint err, diff, p_term, d_term, acc, total, lim;
		logic [pdp_pkg::DRIVE_W-1:0] drv;
		lim = longint'(100) <<< pdp_pkg::GAIN_FRAC_BITS;
		err = longint'(sp_cfg) * 10 - longint'(meas);
		diff = err - longint'(prev_err);
		p_term = err * longint'(kp_cfg);
		d_term = diff * longint'(kd_cfg);
		acc = longint'(integ_acc) + err * longint'(ki_cfg);
		if (acc > longint'(pdp_pkg::INT_MAX))
			acc = longint'(pdp_pkg::INT_MAX);
		else if (acc < longint'(pdp_pkg::INT_MIN))
			acc = longint'(pdp_pkg::INT_MIN);
		integ_acc = acc[pdp_pkg::INT_W-1:0];
		prev_err = err[15:0];
		total = p_term + acc + d_term;
		if (total > lim)
			drv = pdp_pkg::DRIVE_MAX;
		else if (total < 0)
			drv = '0;
		else
			drv = pdp_pkg::DRIVE_W'(total >>> pdp_pkg::GAIN_FRAC_BITS);
		// strong proportional action wipes the integral for the next sample
		if (p_term >= lim || p_term <= -lim)
			integ_acc = '0;
		return drv;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	// apb write: setup cycle, access cycle, register taken when pready is seen
	task automatic reg_write(input logic [1:0] idx, input logic [pdp_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			pdp_pkg::REG_SETPOINT: sp_cfg = val[pdp_pkg::SP_W-1:0];
			pdp_pkg::REG_GAIN_P:   kp_cfg = val[pdp_pkg::GAIN_W-1:0];
			pdp_pkg::REG_GAIN_I:   ki_cfg = val[pdp_pkg::GAIN_W-1:0];
			pdp_pkg::REG_GAIN_D:   kd_cfg = val[pdp_pkg::GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input int sp, input int kp, input int ki, input int kd);
		reg_write(pdp_pkg::REG_SETPOINT, pdp_pkg::DATA_W'(sp));
		reg_write(pdp_pkg::REG_GAIN_P, pdp_pkg::DATA_W'(kp));
		reg_write(pdp_pkg::REG_GAIN_I, pdp_pkg::DATA_W'(ki));
		reg_write(pdp_pkg::REG_GAIN_D, pdp_pkg::DATA_W'(kd));
	endtask

	// sender paused until every drive word is back
	// sampled on the falling edge so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (sample_pend_q.size() != 0 || s_tvalid || drive_exp_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_sample(input int v);
		sample_pend_q.push_back(pdp_pkg::MEAS_W'(v));
	endtask

	// gains biased toward the extremes and toward useful small values
	function automatic int pick_gain();
		int g;
		case ($urandom_range(0, 7))
			0: g = 32767;
			1: g = -32768;
			2: g = 0;
			3: g = $signed(16'($urandom));
			default: begin
				g = $urandom_range(0, 1536);
				if ($urandom_range(0, 3) == 0)
					g = -g;
			end
		endcase
		return g;
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				drive_exp_q.push_back(pid_step(s_tdata[pdp_pkg::MEAS_W-1:0]));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (sample_pend_q.size() != 0) begin
					if (burst_left == 0)
						burst_left = $urandom_range(1, 24);
					s_tvalid <= 1'b1;
					s_tdata <= {{(16-pdp_pkg::MEAS_W){1'b0}}, sample_pend_q.pop_front()};
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: ready follows a 16 bit stall pattern, renewed each time it runs out
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_pat = 16'hFFFF;
			stall_idx = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (drive_exp_q.size() == 0) begin
					report_mismatch("unexpected drive word",
						m_tdata[pdp_pkg::DRIVE_W-1:0], -1);
				end else begin
					exp_drv = drive_exp_q.pop_front();
					if (m_tdata[pdp_pkg::DRIVE_W-1:0] !== exp_drv)
						report_mismatch("drive", m_tdata[pdp_pkg::DRIVE_W-1:0], exp_drv);
				end
			end
			m_tready <= stall_pat[stall_idx];
			stall_idx++;
			if (stall_idx == 16) begin
				stall_idx = 0;
				case ($urandom_range(0, 3))
					0: stall_pat = 16'hFFFF;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom & $urandom & $urandom) | 16'h0001;
					default: stall_pat = 16'($urandom | $urandom);
				endcase
			end
		end
	end

	// stimulus: directed settings first, then random phases
	initial begin
		int rand_items;
		int n;
		int kind;
		int temp;
		int v;
		int sat_meas;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// all gains zero after reset, extreme samples
		push_sample(-2048);
		push_sample(2047);
		wait_idle();

		// pure proportional: zero error, mid drive, clamp high with clear, clamp low
		load_settings(50, 256, 0, 0);
		push_sample(500);
		push_sample(450);
		push_sample(399);
		push_sample(600);
		wait_idle();

		// derivative only at the most negative gain, widest error swings
		load_settings(0, 0, 0, -32768);
		push_sample(0);
		push_sample(2047);
		push_sample(-2048);
		wait_idle();

		// integral builds up, then a large proportional term clears it
		load_settings(100, 256, 256, 0);
		push_sample(990);
		push_sample(990);
		push_sample(800);
		push_sample(1000);
		wait_idle();

		// extreme gains and the top setpoint
		load_settings(127, 32767, -32768, 32767);
		push_sample(1270);
		push_sample(1269);
		push_sample(1271);
		push_sample(-550);
		push_sample(1250);
		wait_idle();

		// tiny gain, fraction bits truncated away
		load_settings(10, 1, 0, 0);
		push_sample(0);
		push_sample(-1000);
		wait_idle();

		rand_items = 0;
		while (rand_items < 800) begin
			wait_idle();
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				// integral runs into its bound: no proportional clear, constant big error
				v = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
				if ($urandom_range(0, 1) == 0) begin
					load_settings(127, 0, v, 0);
					sat_meas = -2048;
				end else begin
					load_settings(0, 0, v, pick_gain());
					sat_meas = 2047;
				end
				n = 45;
				for (int i = 0; i < n; i++)
					push_sample(($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) - 2048
						: sat_meas);
			end else if (kind == 2) begin
				// wide noise over the whole sample field
				load_settings($urandom_range(0, 127), pick_gain(), pick_gain(), pick_gain());
				n = $urandom_range(10, 40);
				for (int i = 0; i < n; i++)
					push_sample($urandom_range(0, 4095) - 2048);
			end else begin
				// plant-like drift around the setpoint
				v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 127
					: $urandom_range(0, 125);
				load_settings(v, pick_gain(), pick_gain(), pick_gain());
				temp = v * 10 + $urandom_range(0, 300) - 150;
				n = $urandom_range(10, 50);
				for (int i = 0; i < n; i++) begin
					temp = temp + $urandom_range(0, 30) - 15;
					if (temp > 2047)
						temp = 2047;
					if (temp < -2048)
						temp = -2048;
					if ($urandom_range(0, 15) == 0)
						push_sample($urandom_range(0, 1800) - 550);
					else
						push_sample(temp);
				end
			end
			rand_items += n;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// hard stop if the stream hangs
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### pid_drive_percent_core.f
sv/pdp_pkg.sv
sv/pdp_regs.sv
sv/pid_drive_percent_core.sv
tb/sv/pid_drive_percent_core_tb.sv
